// ----- hw/rtl/sspg_pkg.sv -----
package sspg_pkg;

    localparam int IMG_COLS     = 640;
    localparam int IMG_ROWS     = 480;
    localparam int MAX_RADII    = 64;
    localparam int MAX_RAYS     = 1024;
    localparam int SINE_ENTRIES = 1024;

    localparam int COORD_W    = 10;
    localparam int RAY_W      = 10;
    localparam int RAYCNT_W   = $clog2(MAX_RAYS) + 1;
    localparam int RAD_W      = $clog2(MAX_RADII);
    localparam int SEG_W      = 11;
    localparam int MARGIN_W   = 9;
    localparam int RADSUM_W   = COORD_W + 1;
    localparam int PHASE_W    = 26;
    localparam int DIV_CNT_W  = $clog2(PHASE_W + 1);
    localparam int IDX_W      = $clog2(SINE_ENTRIES);
    localparam int IDX_SHIFT  = PHASE_W - IDX_W;
    localparam int QUAD       = SINE_ENTRIES / 4;
    localparam int ROM_AW     = IDX_W - 1;
    localparam int SIN_W      = 31;
    localparam int PROD_W     = SIN_W + COORD_W;
    localparam int POS_W      = COORD_W + 2;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int LIM_W      = 2 * (MARGIN_W + 1);
    localparam int BANKS      = 3;
    localparam int BANK_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 64;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_SEGMENTS = 3'd2,
        REG_STEP     = 3'd3,
        REG_INNER    = 3'd4,
        REG_OUTER    = 3'd5,
        REG_MARGIN   = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CAND0,
        ST_CAND1,
        ST_CAND2,
        ST_CAND3,
        ST_CHECK,
        ST_CLOSE,
        ST_READ,
        ST_SQUARE,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic sample;
        logic idle_res;
        logic cand0;
        logic cand1;
        logic cand2;
        logic cand3;
        logic check;
        logic close;
        logic square;
        logic decide;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic all_done;
        logic div_done;
        logic in_image;
        logic ray_over;
        logic last_ray;
        logic out_busy;
    } dp_status_t;

    typedef logic [SIN_W-1:0] sin_tab_t [0:QUAD];

    // quarter wave sine in q30, odd polynomial on the quadrant
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        longint   q1;
        longint   hp;
        longint   f;
        longint   x;
        longint   x2;
        longint   p;
        q1 = 64'sd1073741824;
        hp = 64'sd1686629713;
        for (int k = 0; k <= QUAD; k++) begin
            f  = longint'(k) * (q1 / QUAD);
            x  = (f * hp) >>> 30;
            x2 = (x * x) >>> 30;
            p  = q1 - x2 / 110;
            p  = q1 - ((x2 * p) >>> 30) / 72;
            p  = q1 - ((x2 * p) >>> 30) / 42;
            p  = q1 - ((x2 * p) >>> 30) / 20;
            p  = q1 - ((x2 * p) >>> 30) / 6;
            p  = (x * p) >>> 30;
            if (p > q1) begin
                p = q1;
            end
            if (p < 0) begin
                p = 0;
            end
            tab[k] = SIN_W'(p);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ----- hw/rtl/sspg_div.sv -----
module sspg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [sspg_pkg::SEG_W-1:0]        divisor,
    output logic                              done,
    output logic [sspg_pkg::PHASE_W-1:0]      quotient
);
    import sspg_pkg::*;

    logic [SEG_W-1:0]     rem_reg, rem_next;
    logic [PHASE_W:0]     q_reg, q_next;
    logic [SEG_W-1:0]     d_reg, d_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [SEG_W:0]       trial;

    // dividend is one at its top bit only
    always_comb begin
        trial     = {rem_reg, (cnt_reg == DIV_CNT_W'(PHASE_W))};
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            q_next    = '0;
            d_next    = divisor;
            cnt_next  = DIV_CNT_W'(PHASE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = SEG_W'(trial - {1'b0, d_reg});
                q_next   = {q_reg[PHASE_W-1:0], 1'b1};
            end else begin
                rem_next = SEG_W'(trial);
                q_next   = {q_reg[PHASE_W-1:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = !busy_reg;
    assign quotient = q_reg[PHASE_W-1:0];

endmodule

// ----- hw/rtl/sspg_ctrl.sv -----
module sspg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   op,
    output logic                   s_tready,
    output sspg_pkg::ctrl_cmd_t    cmd,
    input  sspg_pkg::dp_status_t   status
);
    import sspg_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        accept     = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op == OP_START) begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIV;
                    end else if (status.all_done) begin
                        cmd.idle_res = 1'b1;
                        state_next   = ST_EMIT;
                    end else begin
                        cmd.sample = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_CAND0;
                end
            end
            ST_CAND0: begin
                cmd.cand0  = 1'b1;
                state_next = ST_CAND1;
            end
            ST_CAND1: begin
                cmd.cand1  = 1'b1;
                state_next = ST_CAND2;
            end
            ST_CAND2: begin
                cmd.cand2  = 1'b1;
                state_next = ST_CAND3;
            end
            ST_CAND3: begin
                cmd.cand3  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = status.in_image ? ST_EMIT : ST_CLOSE;
            end
            ST_CLOSE: begin
                cmd.close  = 1'b1;
                state_next = status.last_ray ? ST_EMIT : ST_CAND0;
            end
            ST_READ: begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.ray_over ? ST_CLOSE : ST_CAND0;
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sspg_dp.sv -----
module sspg_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [sspg_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sspg_pkg::OUT_W-1:0]        m_tdata,
    input  sspg_pkg::ctrl_cmd_t               cmd,
    output sspg_pkg::dp_status_t              status
);
    import sspg_pkg::*;

    // configuration registers
    logic [COORD_W-1:0]  cx_reg, cy_reg, step_reg, inner_reg, outer_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // working copies
    logic [COORD_W-1:0]  w_cx_reg, w_cy_reg, w_step_reg, w_inner_reg, w_outer_reg;
    logic [RAYCNT_W-1:0] w_rays_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic                m_nz_reg;

    logic [RAYCNT_W-1:0] ray_cnt_reg;
    logic [RAD_W-1:0]    rad_cnt_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [RADSUM_W-1:0] radius_reg;
    logic [COORD_W-1:0]  pend_x_reg, pend_y_reg;
    logic                on_first_reg, all_done_reg;
    logic [BANK_W-1:0]   first_bank_reg, prev_bank_reg, cur_bank_reg;
    logic [MAX_RADII-1:0] valid_reg [BANKS];

    logic                pass_reg;
    logic [SIN_W-1:0]    rom_reg;
    logic                rom_neg_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                prod_neg_reg;
    logic [POS_W-1:0]    px_reg, py_reg;
    logic [SQ_W-1:0]     sqf_x_reg, sqf_y_reg, sqp_x_reg, sqp_y_reg;
    logic                vf_reg, vp_reg;

    logic                res_acc_reg;
    logic [COORD_W-1:0]  res_x_reg, res_y_reg;
    logic [RAY_W-1:0]    res_ray_reg;
    logic [RAD_W-1:0]    res_rad_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [SEG_W-1:0]    seg_clamp;
    logic [MARGIN_W-1:0] half_step, margin_eff;
    logic [MARGIN_W:0]   twice_m;
    logic                div_done;
    logic [PHASE_W-1:0]  phase_inc;

    logic [PHASE_W-1:0]  phase_sum;
    logic [IDX_W-1:0]    idx_sin, idx;
    logic [ROM_AW-1:0]   rom_addr;
    logic [PROD_W:0]     rounded;
    logic [COORD_W:0]    mag;
    logic [COORD_W-1:0]  center;
    logic [POS_W-1:0]    coord;
    logic                in_image;

    logic [2*COORD_W-1:0] rd_q [BANKS];
    logic [2*COORD_W-1:0] wr_data;
    logic [2*COORD_W-1:0] f_q, p_q;
    logic signed [COORD_W:0]     dfx, dfy, dpx, dpy;
    logic signed [2*COORD_W+1:0] tfx, tfy, tpx, tpy;
    logic [DIST_W-1:0]   sum_f, sum_p;
    logic                far_f, far_p, acc;
    logic [RADSUM_W-1:0] radius_add;
    logic                ray_over, last_ray;
    logic [BANK_W-1:0]   nf_bank, nc_bank;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= COORD_W'(320);
            cy_reg     <= COORD_W'(240);
            seg_reg    <= SEG_W'(36);
            step_reg   <= COORD_W'(10);
            inner_reg  <= '0;
            outer_reg  <= COORD_W'(200);
            margin_reg <= MARGIN_W'(2);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X: cx_reg     <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y: cy_reg     <= cfg_data[COORD_W-1:0];
                REG_SEGMENTS: seg_reg    <= cfg_data;
                REG_STEP:     step_reg   <= cfg_data[COORD_W-1:0];
                REG_INNER:    inner_reg  <= cfg_data[COORD_W-1:0];
                REG_OUTER:    outer_reg  <= cfg_data[COORD_W-1:0];
                REG_MARGIN:   margin_reg <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // start values
    always_comb begin
        if (seg_reg == '0) begin
            seg_clamp = SEG_W'(1);
        end else if (seg_reg > SEG_W'(MAX_RAYS)) begin
            seg_clamp = SEG_W'(MAX_RAYS);
        end else begin
            seg_clamp = seg_reg;
        end
        half_step  = step_reg[COORD_W-1:1];
        margin_eff = (margin_reg > half_step) ? half_step : margin_reg;
        twice_m    = {margin_eff, 1'b0};
    end

    sspg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start),
        .divisor  (seg_clamp),
        .done     (div_done),
        .quotient (phase_inc)
    );

    // candidate position
    always_comb begin
        phase_sum = phase_reg + PHASE_W'(1 << (IDX_SHIFT - 1));
        idx_sin   = phase_sum[PHASE_W-1 -: IDX_W];
        idx       = cmd.cand1 ? IDX_W'(idx_sin + IDX_W'(QUAD)) : idx_sin;
        if (idx[IDX_W-2]) begin
            rom_addr = ROM_AW'(QUAD) - ROM_AW'(idx[IDX_W-3:0]);
        end else begin
            rom_addr = ROM_AW'(idx[IDX_W-3:0]);
        end
        rounded  = {1'b0, prod_reg} + (PROD_W+1)'(1 << 29);
        mag      = rounded[PROD_W-1:30];
        center   = cmd.cand3 ? w_cy_reg : w_cx_reg;
        if (prod_neg_reg) begin
            coord = {2'b00, center} - {1'b0, mag};
        end else begin
            coord = {2'b00, center} + {1'b0, mag};
        end
        in_image = !px_reg[POS_W-1] && (px_reg < POS_W'(IMG_COLS))
                && !py_reg[POS_W-1] && (py_reg < POS_W'(IMG_ROWS));
    end

    always_ff @(posedge aclk) begin
        if (cmd.cand0 || cmd.cand1) begin
            rom_reg     <= SIN_TAB[rom_addr];
            rom_neg_reg <= idx[IDX_W-1];
        end
        if (cmd.cand1 || cmd.cand2) begin
            prod_reg     <= rom_reg * PROD_W'(radius_reg[COORD_W-1:0]);
            prod_neg_reg <= rom_neg_reg;
        end
        if (cmd.cand2) begin
            px_reg <= coord;
        end
        if (cmd.cand3) begin
            py_reg <= coord;
        end
    end

    // point stores
    assign wr_data = {pend_y_reg, pend_x_reg};

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [2*COORD_W-1:0] mem [MAX_RADII];
        always_ff @(posedge aclk) begin
            if (cmd.decide && acc && (cur_bank_reg == BANK_W'(b))) begin
                mem[rad_cnt_reg] <= wr_data;
            end
            rd_q[b] <= mem[rad_cnt_reg];
        end
    end

    // spacing test
    always_comb begin
        f_q = rd_q[first_bank_reg];
        p_q = rd_q[prev_bank_reg];
        dfx = $signed({1'b0, pend_x_reg}) - $signed({1'b0, f_q[COORD_W-1:0]});
        dfy = $signed({1'b0, pend_y_reg}) - $signed({1'b0, f_q[2*COORD_W-1:COORD_W]});
        dpx = $signed({1'b0, pend_x_reg}) - $signed({1'b0, p_q[COORD_W-1:0]});
        dpy = $signed({1'b0, pend_y_reg}) - $signed({1'b0, p_q[2*COORD_W-1:COORD_W]});
        tfx = dfx * dfx;
        tfy = dfy * dfy;
        tpx = dpx * dpx;
        tpy = dpy * dpy;
        sum_f = {1'b0, sqf_x_reg} + {1'b0, sqf_y_reg};
        sum_p = {1'b0, sqp_x_reg} + {1'b0, sqp_y_reg};
        far_f = vf_reg ? (sum_f > DIST_W'(lim_reg)) : m_nz_reg;
        far_p = vp_reg ? (sum_p > DIST_W'(lim_reg)) : m_nz_reg;
        acc   = pass_reg && (on_first_reg || (far_f && far_p));
        radius_add = radius_reg + RADSUM_W'(w_step_reg);
        ray_over   = (radius_add > RADSUM_W'(w_outer_reg))
                  || (rad_cnt_reg == RAD_W'(MAX_RADII - 1));
        last_ray   = (RAYCNT_W'(ray_cnt_reg + 1'b1) >= w_rays_reg);
        nf_bank    = on_first_reg ? cur_bank_reg : first_bank_reg;
        if (nf_bank == cur_bank_reg) begin
            nc_bank = (cur_bank_reg == BANK_W'(BANKS - 1)) ? '0 : cur_bank_reg + 1'b1;
        end else begin
            nc_bank = BANK_W'(BANKS) - nf_bank - cur_bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sqf_x_reg <= tfx[SQ_W-1:0];
            sqf_y_reg <= tfy[SQ_W-1:0];
            sqp_x_reg <= tpx[SQ_W-1:0];
            sqp_y_reg <= tpy[SQ_W-1:0];
            vf_reg    <= valid_reg[first_bank_reg][rad_cnt_reg];
            vp_reg    <= valid_reg[prev_bank_reg][rad_cnt_reg];
        end
        if (cmd.sample) begin
            pass_reg <= (s_tdata[7:0] != 8'd0) && (s_tdata[15:8] != 8'd127)
                     && (s_tdata[23:16] != 8'd127);
        end
        if (cmd.start) begin
            w_cx_reg    <= cx_reg;
            w_cy_reg    <= cy_reg;
            w_step_reg  <= step_reg;
            w_inner_reg <= inner_reg;
            w_outer_reg <= outer_reg;
            w_rays_reg  <= seg_clamp;
            lim_reg     <= twice_m * twice_m;
            m_nz_reg    <= (margin_eff != '0);
        end
        if (cmd.start || cmd.idle_res) begin
            res_acc_reg <= 1'b0;
            res_x_reg   <= '0;
            res_y_reg   <= '0;
            res_ray_reg <= '0;
            res_rad_reg <= '0;
        end else if (cmd.decide) begin
            res_acc_reg <= acc;
            res_x_reg   <= pend_x_reg;
            res_y_reg   <= pend_y_reg;
            res_ray_reg <= ray_cnt_reg[RAY_W-1:0];
            res_rad_reg <= rad_cnt_reg;
        end
        if (cmd.check && in_image) begin
            pend_x_reg <= px_reg[COORD_W-1:0];
            pend_y_reg <= py_reg[COORD_W-1:0];
        end
    end

    // walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_cnt_reg    <= '0;
            rad_cnt_reg    <= '0;
            phase_reg      <= '0;
            radius_reg     <= '0;
            on_first_reg   <= 1'b1;
            all_done_reg   <= 1'b1;
            first_bank_reg <= '0;
            prev_bank_reg  <= '0;
            cur_bank_reg   <= '0;
            for (int b = 0; b < BANKS; b++) begin
                valid_reg[b] <= '0;
            end
        end else if (cmd.start) begin
            ray_cnt_reg    <= '0;
            rad_cnt_reg    <= '0;
            phase_reg      <= '0;
            radius_reg     <= RADSUM_W'(inner_reg);
            on_first_reg   <= 1'b1;
            all_done_reg   <= 1'b0;
            first_bank_reg <= '0;
            prev_bank_reg  <= '0;
            cur_bank_reg   <= '0;
            for (int b = 0; b < BANKS; b++) begin
                valid_reg[b] <= '0;
            end
        end else if (cmd.decide) begin
            if (acc) begin
                valid_reg[cur_bank_reg][rad_cnt_reg] <= 1'b1;
            end
            rad_cnt_reg <= rad_cnt_reg + 1'b1;
            radius_reg  <= radius_add;
        end else if (cmd.close) begin
            first_bank_reg      <= nf_bank;
            prev_bank_reg       <= cur_bank_reg;
            cur_bank_reg        <= nc_bank;
            valid_reg[nc_bank]  <= '0;
            on_first_reg        <= 1'b0;
            ray_cnt_reg         <= ray_cnt_reg + 1'b1;
            if (last_ray) begin
                all_done_reg <= 1'b1;
            end else begin
                phase_reg   <= phase_reg + phase_inc;
                rad_cnt_reg <= '0;
                radius_reg  <= RADSUM_W'(w_inner_reg);
            end
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {5'd0, all_done_reg, !all_done_reg,
                            all_done_reg ? COORD_W'(0) : pend_y_reg,
                            all_done_reg ? COORD_W'(0) : pend_x_reg,
                            res_rad_reg, res_ray_reg, res_y_reg, res_x_reg, res_acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.all_done = all_done_reg;
    assign status.div_done = div_done;
    assign status.in_image = in_image;
    assign status.ray_over = ray_over;
    assign status.last_ray = last_ray;
    assign status.out_busy = m_tvalid_reg && !m_tready;

endmodule

// ----- hw/rtl/star_scan_point_generator.sv -----
// a sample word goes through read, square and decide, then the candidate sequencer,
// plus a close for each ray that is closed on the way; a start word goes through the
// 27-step phase increment divider and the candidate sequencer (rom, multiply, round)
// one word is in work at a time; the next is taken while the result word waits
// aresetn is synchronous and active low: config and control registers return to their
// defaults, the block reports finished and all point stores read as absent at once
module star_scan_point_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sspg_pkg::IN_W-1:0]         s_tdata,  // mask_y, mask_u, mask_v
    input  logic                              s_tuser,  // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sspg_pkg::OUT_W-1:0]        m_tdata,  // accepted, point_x, point_y,
                                                        // ray_number, radius_number,
                                                        // request_x, request_y,
                                                        // request_valid, finished
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sspg_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sspg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sspg_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
